### design/gwtc_pkg.sv
// ----------------------------------------------------------------------------
// gwtc_pkg: shared types and constants for the GPS week to calendar converter
// Request and result layouts, controller states, the command and status
// bundles between controller and datapath, and the month length table.
// ----------------------------------------------------------------------------
`default_nettype none

package gwtc_pkg;

  // Request and result payloads.
  typedef struct packed {
    logic [15:0] week_number;
    logic [30:0] week_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] year_since_2000;
    logic [3:0] month_number;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } out_item_t;

  // Time constants.
  localparam int unsigned MsPerSecond    = 1000;
  localparam int unsigned SecondsPerWeek = 604800;
  localparam int unsigned SecondsPerDay  = 86400;
  localparam int unsigned SecondsPerHour = 3600;
  localparam int unsigned SecondsPerMin  = 60;
  localparam int unsigned EpochYear      = 1980;
  localparam int unsigned EpochDayOffset = 5;
  localparam int unsigned BaseYear       = 2000;
  localparam int unsigned LeapYearDays   = 366;
  localparam int unsigned CommonYearDays = 365;
  localparam logic [3:0]  LastMonth      = 4'd12;
  localparam logic [3:0]  February       = 4'd2;

  // Milliseconds to seconds: with y = ms >> 3 (28 bits), y / 125 equals
  // (y * MsPerSecondRecip) >> MsRecipShift for every 31-bit millisecond count.
  localparam logic [28:0] MsPerSecondRecip = 29'd274877907;
  localparam int unsigned MsRecipShift     = 35;

  // Controller states.
  typedef enum logic [3:0] {
    IDLE,
    DIVIDE,
    FOLD,
    LOOKUP,
    YEAR_SCAN,
    MONTH_SCAN,
    DAY_CARRY,
    HOUR_COUNT,
    MINUTE_COUNT,
    DELIVER
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic fold;
    logic lookup;
    logic year_step;
    logic month_step;
    logic month_fin;
    logic day_step;
    logic hour_step;
    logic minute_step;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cache_hit;
    logic year_done;
    logic month_done;
    logic day_done;
    logic hour_done;
    logic minute_done;
  } status_t;

  // Days in a month; leap years follow the divisible-by-four rule only.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    begin
      unique case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        February:                                   len = leap ? 5'd29 : 5'd28;
        default:                                    len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

### design/gwtc_ctrl.sv
// ----------------------------------------------------------------------------
// gwtc_ctrl: sequencing controller
// Walks each request through division, week fold, cache lookup, year and
// month scans (skipped on a cache hit), day carry and hour/minute counting,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwtc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  gwtc_pkg::status_t status,
  output gwtc_pkg::cmd_t    cmd
);
  import gwtc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:         if (in_valid)           state_next = DIVIDE;
      DIVIDE:                               state_next = FOLD;
      FOLD:                                 state_next = LOOKUP;
      LOOKUP:       state_next = status.cache_hit ? DAY_CARRY : YEAR_SCAN;
      YEAR_SCAN:    if (status.year_done)   state_next = MONTH_SCAN;
      MONTH_SCAN:   if (status.month_done)  state_next = DAY_CARRY;
      DAY_CARRY:    if (status.day_done)    state_next = HOUR_COUNT;
      HOUR_COUNT:   if (status.hour_done)   state_next = MINUTE_COUNT;
      MINUTE_COUNT: if (status.minute_done) state_next = DELIVER;
      DELIVER:      if (!out_valid || out_ready) state_next = IDLE;
      default:                              state_next = IDLE;
    endcase
  end

  // Outputs: commands, ready and the result valid flag.
  always_comb begin
    cmd             = '0;
    in_ready        = (state == IDLE);
    cmd.load        = (state == IDLE) && in_valid;
    cmd.div_step    = (state == DIVIDE);
    cmd.fold        = (state == FOLD);
    cmd.lookup      = (state == LOOKUP);
    cmd.year_step   = (state == YEAR_SCAN) && !status.year_done;
    cmd.month_step  = (state == MONTH_SCAN) && !status.month_done;
    cmd.month_fin   = (state == MONTH_SCAN) && status.month_done;
    cmd.day_step    = (state == DAY_CARRY) && !status.day_done;
    cmd.hour_step   = (state == HOUR_COUNT) && !status.hour_done;
    cmd.minute_step = (state == MINUTE_COUNT) && !status.minute_done;
    cmd.out_load    = (state == DELIVER) && (!out_valid || out_ready);
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

### design/gwtc_dp.sv
// ----------------------------------------------------------------------------
// gwtc_dp: conversion datapath
// Holds the working registers, the reciprocal multiplier that turns
// milliseconds into seconds, the week date cache and the output register,
// stepping on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gwtc_dp (
  input  wire                 clk,
  input  wire                 rst,
  input  gwtc_pkg::in_item_t  in_data,
  input  gwtc_pkg::cmd_t      cmd,
  output gwtc_pkg::status_t   status,
  output gwtc_pkg::out_item_t out_data
);
  import gwtc_pkg::*;

  // Working registers.
  logic [27:0] ms_eighths;
  logic [21:0] secs;
  logic [15:0] week;
  logic [18:0] days;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;

  // Cached start-of-week date.
  logic        cache_valid;
  logic [15:0] cache_week;
  logic [11:0] cache_year;
  logic [3:0]  cache_month;
  logic [4:0]  cache_day;

  // Combinational helpers.
  logic [56:0] ms_prod;
  logic [8:0]  year_len;
  logic [4:0]  mlen;
  logic [5:0]  day_inc;
  logic [18:0] week_days;

  // Reciprocal product (28 by 29 bits), year and month lengths, day increment, epoch day count.
  always_comb begin
    ms_prod   = {29'd0, ms_eighths} * {28'd0, MsPerSecondRecip};
    year_len  = (year[1:0] == 2'b00) ? 9'(LeapYearDays) : 9'(CommonYearDays);
    mlen      = month_len(year[1:0] == 2'b00, month);
    day_inc   = {1'b0, day} + 6'd1;
    week_days = 19'({week, 3'b000}) - 19'(week) + 19'(EpochDayOffset);
  end

  // Status back to the controller.
  always_comb begin
    status.cache_hit   = cache_valid && (cache_week == week);
    status.year_done   = (days < 19'(year_len));
    status.month_done  = !((month < LastMonth) && (days >= 19'(mlen)));
    status.day_done    = (secs < 22'(SecondsPerDay));
    status.hour_done   = (secs < 22'(SecondsPerHour));
    status.minute_done = (secs < 22'(SecondsPerMin));
  end

  // Cache valid flag is control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_valid <= 1'b0;
    end else if (cmd.month_fin) begin
      cache_valid <= 1'b1;
    end
  end

  // Cache contents, written when a fresh week date is found.
  always_ff @(posedge clk) begin
    if (cmd.month_fin) begin
      cache_week  <= week;
      cache_year  <= year;
      cache_month <= month;
      cache_day   <= 5'(days + 19'd1);
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ms_eighths <= in_data.week_time_ms[30:3];
      week       <= in_data.week_number;
      secs       <= '0;
      hour       <= '0;
      minute     <= '0;
    end
    // Whole seconds of the time of week from the reciprocal product.
    if (cmd.div_step) begin
      secs <= ms_prod[MsRecipShift +: 22];
    end
    // Fold a whole week of seconds into the week number.
    if (cmd.fold && (secs >= 22'(SecondsPerWeek))) begin
      secs <= secs - 22'(SecondsPerWeek);
      week <= week + 16'd1;
    end
    // Take the date from the cache or start the scan from the epoch.
    if (cmd.lookup) begin
      if (status.cache_hit) begin
        year  <= cache_year;
        month <= cache_month;
        day   <= cache_day;
      end else begin
        days  <= week_days;
        year  <= 12'(EpochYear);
        month <= 4'd1;
      end
    end
    if (cmd.year_step) begin
      days <= days - 19'(year_len);
      year <= year + 12'd1;
    end
    if (cmd.month_step) begin
      days  <= days - 19'(mlen);
      month <= month + 4'd1;
    end
    if (cmd.month_fin) begin
      day <= 5'(days + 19'd1);
    end
    // Carry whole days of the time of week into the date.
    if (cmd.day_step) begin
      secs <= secs - 22'(SecondsPerDay);
      if (day_inc > {1'b0, mlen}) begin
        day <= 5'd1;
        if (month == LastMonth) begin
          month <= 4'd1;
          year  <= year + 12'd1;
        end else begin
          month <= month + 4'd1;
        end
      end else begin
        day <= day_inc[4:0];
      end
    end
    if (cmd.hour_step) begin
      secs <= secs - 22'(SecondsPerHour);
      hour <= hour + 5'd1;
    end
    if (cmd.minute_step) begin
      secs   <= secs - 22'(SecondsPerMin);
      minute <= minute + 6'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.year_since_2000  <= 8'(year - 12'(BaseYear));
      out_data.month_number     <= month;
      out_data.day_of_month     <= day;
      out_data.hour_of_day      <= hour;
      out_data.minute_of_hour   <= minute;
      out_data.second_of_minute <= secs[5:0];
    end
  end

endmodule

`default_nettype wire

### design/gps_week_to_calendar_time.sv
// ----------------------------------------------------------------------------
// gps_week_to_calendar_time: GPS week and time of week to calendar date
// Top level joining the sequencing controller and the conversion datapath.
// ----------------------------------------------------------------------------
// Converts a GPS week number and millisecond time of week into year (minus
// 2000, modulo 256), month, day, hour, minute and second, leap seconds
// ignored and leap years by the divisible-by-four rule. One request is
// processed at a time. After acceptance, a request passes through the
// millisecond-to-second reciprocal multiply, the week fold and the cache
// lookup; then, on a week other than the cached one, a year scan that steps
// one year at a time from 1980 and the month scan; after that the day
// carry (a time of week near the 31-bit limit leaves 17 whole days after the
// fold), hour and minute counting and delivery. The finished result sits in
// an output register, so a new request is taken while it waits.
`default_nettype none

module gps_week_to_calendar_time (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  gwtc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output gwtc_pkg::out_item_t out_data
);
  import gwtc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller.
  gwtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  gwtc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // A delivered time of day is always in range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hour_of_day < 5'd24) && (out_data.minute_of_hour < 6'd60)
                  && (out_data.second_of_minute < 6'd60))
    else $error("result time of day out of range");

  // A delivered date has a real month and day.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.month_number >= 4'd1) && (out_data.month_number <= 4'd12)
                  && (out_data.day_of_month >= 5'd1))
    else $error("result date out of range");

  // Once a request is taken, the block is busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a conversion is starting");

  // The output register only loads when it is free or being emptied.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire

### sim/gps_week_to_calendar_time_tb.sv
// ----------------------------------------------------------------------------
// gps_week_to_calendar_time_tb: self-checking bench for the GPS date converter
// Drives GPS week and time-of-week requests through the valid/ready port,
// predicts each calendar date and time in the bench, and compares every
// result field in order. Directed cases cover the epoch, field extremes,
// week folding and rollover, long day carries, leap days, far-future years
// and the cached week. Random traffic then runs with and without idling.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_week_to_calendar_time_tb;

  import gwtc_pkg::*;

  localparam int unsigned DaysPerFourYears = 1461;
  localparam int unsigned DrainCycles      = 2000;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Idle rates, in percent of cycles, for each side of the port.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count = 0;

  // Dates still owed by the block, oldest first.
  out_item_t pending_dates[$];

  // Bench copy of the last-week cache.
  logic        last_week_valid;
  logic [15:0] last_week;
  int unsigned last_week_year;
  int unsigned last_week_month;
  int unsigned last_week_day;

  gps_week_to_calendar_time dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Month length with the divisible-by-four leap rule.
  function automatic int unsigned days_in_month(input int unsigned year,
                                                input int unsigned month);
    if (month == 32'(February)) begin
      return (year % 4 == 0) ? 29 : 28;
    end
    if (month == 4 || month == 6 || month == 9 || month == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // Expected calendar date and time of one request; updates the week cache.
  function automatic out_item_t calendar_of(input in_item_t req);
    logic [15:0] week;
    int unsigned secs;
    int unsigned days;
    int unsigned year;
    int unsigned month;
    int unsigned day;
    int unsigned ylen;
    out_item_t   date;
    week = req.week_number;
    secs = req.week_time_ms / MsPerSecond;
    // A time of week past one week moves one week into the week number.
    if (secs >= SecondsPerWeek) begin
      secs = secs - SecondsPerWeek;
      week = week + 16'd1;
    end
    if (last_week_valid && last_week == week) begin
      year  = last_week_year;
      month = last_week_month;
      day   = last_week_day;
    end else begin
      days  = int'(week) * 7 + EpochDayOffset;
      // 1980 is a leap year, so whole four-year blocks can be skipped at once.
      year  = EpochYear + 4 * (days / DaysPerFourYears);
      days  = days % DaysPerFourYears;
      forever begin
        ylen = (year % 4 == 0) ? LeapYearDays : CommonYearDays;
        if (days < ylen) break;
        days = days - ylen;
        year++;
      end
      month = 1;
      while (month < 32'(LastMonth) && days >= days_in_month(year, month)) begin
        days = days - days_in_month(year, month);
        month++;
      end
      day = days + 1;
      last_week_valid = 1'b1;
      last_week       = week;
      last_week_year  = year;
      last_week_month = month;
      last_week_day   = day;
    end
    // Carry whole days of the time of week into the date.
    while (secs >= SecondsPerDay) begin
      secs = secs - SecondsPerDay;
      day++;
      if (day > days_in_month(year, month)) begin
        day = 1;
        month++;
        if (month > 32'(LastMonth)) begin
          month = 1;
          year++;
        end
      end
    end
    date.year_since_2000  = 8'(year - BaseYear);
    date.month_number     = 4'(month);
    date.day_of_month     = 5'(day);
    date.hour_of_day      = 5'(secs / SecondsPerHour);
    secs = secs % SecondsPerHour;
    date.minute_of_hour   = 6'(secs / SecondsPerMin);
    date.second_of_minute = 6'(secs % SecondsPerMin);
    return date;
  endfunction

  // Present one request, hold it until taken, then log its expected date.
  task automatic send_request(input logic [15:0] week, input logic [30:0] ms);
    in_item_t req;
    req.week_number  = week;
    req.week_time_ms = ms;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_dates.push_back(calendar_of(req));
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random back-pressure and an in-order check of every result.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          mismatch_count++;
        end else begin
          want = pending_dates.pop_front();
          check_field("year_since_2000", 32'(want.year_since_2000),
                      32'(out_data.year_since_2000));
          check_field("month_number", 32'(want.month_number),
                      32'(out_data.month_number));
          check_field("day_of_month", 32'(want.day_of_month),
                      32'(out_data.day_of_month));
          check_field("hour_of_day", 32'(want.hour_of_day),
                      32'(out_data.hour_of_day));
          check_field("minute_of_hour", 32'(want.minute_of_hour),
                      32'(out_data.minute_of_hour));
          check_field("second_of_minute", 32'(want.second_of_minute),
                      32'(out_data.second_of_minute));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Epoch, field extremes and alternating bit patterns.
  task automatic test_epoch_and_extremes();
    send_request(16'd0, 31'd0);
    send_request(16'd0, 31'd999);
    send_request(16'd0, 31'd1000);
    send_request(16'd0, 31'd86399999);
    send_request(16'd0, 31'd604799999);
    send_request(16'hFFFF, 31'd0);
    send_request(16'hAAAA, 31'h2AAAAAAA);
    send_request(16'h5555, 31'h55555555);
  endtask

  // Week fold, rollover of the week number and long day carries.
  task automatic test_rollover_and_carry();
    send_request(16'd0, 31'd1209599999);
    send_request(16'hFFFF, 31'd604800000);
    send_request(16'hFFFF, 31'h7FFFFFFF);
    send_request(16'd51, 31'h7FFFFFFF);
  endtask

  // Leap day, mod-4 years past 2099 and years that wrap the year field.
  task automatic test_calendar_edges();
    send_request(16'd7, 31'd432000000);
    send_request(16'd7, 31'd518400000);
    send_request(16'd1042, 31'd345600000);
    send_request(16'd6260, 31'd0);
    send_request(16'd6265, 31'd604799999);
    send_request(16'd14500, 31'd123456789);
    send_request(16'd200, 31'd1000000000);
  endtask

  // Repeated weeks, including one reached only through the fold.
  task automatic test_cached_week();
    send_request(16'd2300, 31'd100);
    send_request(16'd2300, 31'd500000000);
    send_request(16'd2299, 31'd604800000);
    send_request(16'd2301, 31'd0);
    send_request(16'd2300, 31'd86400000);
  endtask

  // Mostly recent weeks with repeats, some weeks anywhere in range.
  task automatic test_random_traffic(input int count);
    logic [15:0] week;
    logic [30:0] ms;
    int unsigned pick;
    week = 16'd1500;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick >= 30 && pick < 85) begin
        week = 16'($urandom_range(3000, 1000));
      end else if (pick >= 85) begin
        week = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        ms = 31'($urandom_range(604799999));
      end else if (pick < 92) begin
        ms = 31'($urandom_range(1209599999, 604800000));
      end else begin
        ms = 31'($urandom);
      end
      send_request(week, ms);
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    in_data         = '0;
    last_week_valid = 1'b0;
    send_idle_pct   = 34;
    recv_idle_pct   = 56;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_epoch_and_extremes();
    test_rollover_and_carry();
    test_calendar_edges();
    test_cached_week();
    test_random_traffic(132);
    send_idle_pct = 56;
    recv_idle_pct = 34;
    test_random_traffic(132);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(132);
    in_valid <= 1'b0;

    // Let the last results drain, then allow for anything still in flight.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("gps_week_to_calendar_time_tb passed");
    end else begin
      $display("gps_week_to_calendar_time_tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #50000000;
    $display("gps_week_to_calendar_time_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
